[src/dtq_pkg.sv]
package dtq_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INGRESS_DELAY    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SERVICE_TIME     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUEUE_CAPACITY   = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIXED_PATH_DELAY = 2'd3;

   // Field widths fixed by the interface
   localparam int CAP_WIDTH   = 5;
   localparam int TOTAL_WIDTH = 32;
   localparam int SUM_WIDTH   = 64;

   // Register reset values
   localparam logic [CSR_DATA_WIDTH-1:0] INGRESS_DELAY_RESET    = 32'd0;
   localparam logic [CSR_DATA_WIDTH-1:0] SERVICE_TIME_RESET     = 32'd1;
   localparam logic [CAP_WIDTH-1:0]      QUEUE_CAPACITY_RESET   = 5'd16;
   localparam logic [CSR_DATA_WIDTH-1:0] FIXED_PATH_DELAY_RESET = 32'd0;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOK   = 3'b010,
      ST_COMMIT = 3'b100
   } dtq_state_type;

   // Queue operations requested by the sequencer
   typedef struct packed {
      logic pop;
      logic push;
   } dtq_fifo_ctrl_type;

endpackage

[src/dtq_ram.sv]
module dtq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/dtq_fifo.sv]
module dtq_fifo import dtq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TIME_WIDTH  = 48,
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dtq_fifo_ctrl_type     ctrl,
   input  logic [TIME_WIDTH-1:0] push_time,
   output logic [CW-1:0]         count,
   output logic [TIME_WIDTH-1:0] head_time
);

   localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);

   logic [AW-1:0]         head_ff, head_in;
   logic [AW-1:0]         tail_ff, tail_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  fwd_ff, fwd_in;
   logic [TIME_WIDTH-1:0] fwd_time_ff;
   logic [AW-1:0]         rd_addr;
   logic [TIME_WIDTH-1:0] rd_data;

   // Advance the ring pointers and the fill count
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctrl.pop) begin
         head_in  = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
      if (ctrl.push) begin
         tail_in  = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
   end

   // Read the entry that will be head next cycle
   assign rd_addr = head_in;

   // Forward a write that lands on the entry being read
   assign fwd_in = ctrl.push && (tail_ff == rd_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         fwd_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         fwd_ff   <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_time_ff <= push_time;
   end

   dtq_ram #(
      .WIDTH (TIME_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctrl.push),
      .wr_addr (tail_ff),
      .wr_data (push_time),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign head_time = fwd_ff ? fwd_time_ff : rd_data;
   assign count     = count_ff;

endmodule

[src/drop_tail_queue_delay_model_top.sv]
// Drop-tail FIFO queue with one server, timed in integer ticks.
// Input channel (req_): one item per packet, carrying its generation time;
// generation times are expected in non-decreasing order. Result channel
// (rsp_): one item per input, giving drop flag, queue delay, end-to-end
// delay, departure time, occupancy and saturating running totals.
// Configuration (csr_): single-cycle writes of ingress delay, service time,
// queue capacity and fixed path delay; write only while the block is idle.
// Steps: an item is taken, then the head departure time is looked at, each
// queued packet that has departed by the arrival is retired in turn, and
// the result is committed into the output register. Retirement is paced by
// the single read port of the departure memory, which yields one head entry
// per cycle. Each entry is retired once.
// Reset (synchronous, active high) empties the queue, clears all totals and
// restores the register defaults; the departure memory is not cleared.
// When the receiver stalls, the result is held in the output register and
// the next item is still taken and worked on up to its commit step.
module drop_tail_queue_delay_model_top import dtq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TIME_WIDTH  = 48,
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   // input items
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [TIME_WIDTH-1:0]      req_gen_time,
   // result items
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_was_dropped,
   output logic [TIME_WIDTH-1:0]      rsp_queue_delay,
   output logic [TIME_WIDTH-1:0]      rsp_end_to_end_delay,
   output logic [TIME_WIDTH-1:0]      rsp_depart_time,
   output logic [CW-1:0]              rsp_occupancy,
   output logic [CW-1:0]              rsp_peak_occupancy,
   output logic [TOTAL_WIDTH-1:0]     rsp_delivered_total,
   output logic [TOTAL_WIDTH-1:0]     rsp_dropped_total,
   output logic [SUM_WIDTH-1:0]       rsp_queue_delay_total,
   // configuration
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int SW = ((TIME_WIDTH > CSR_DATA_WIDTH) ? TIME_WIDTH : CSR_DATA_WIDTH) + 1;
   localparam logic [TIME_WIDTH-1:0]  TIME_MAX  = '1;
   localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;
   localparam logic [SUM_WIDTH-1:0]   SUM_MAX   = '1;
   localparam logic [CW-1:0]          DEPTH_CNT = CW'(QUEUE_DEPTH);

   dtq_state_type          state_ff, state_in;
   logic [CSR_DATA_WIDTH-1:0] ingress_ff, service_ff, fixed_ff;
   logic [CAP_WIDTH-1:0]   capacity_ff;
   logic [TIME_WIDTH-1:0]  arrival_ff, arrival_in;
   logic [TIME_WIDTH-1:0]  server_free_ff;
   logic [TIME_WIDTH-1:0]  start_ff, start_in;
   logic [TIME_WIDTH-1:0]  qdelay_ff, qdelay_in;
   logic [CW-1:0]          peak_ff, peak_in;
   logic [TOTAL_WIDTH-1:0] accepted_ff, accepted_in;
   logic [TOTAL_WIDTH-1:0] discard_ff, discard_in;
   logic [SUM_WIDTH-1:0]   wait_sum_ff, wait_sum_in;
   logic                   rsp_valid_ff;
   logic                   rsp_dropped_ff;
   logic [TIME_WIDTH-1:0]  rsp_qdelay_ff, rsp_e2e_ff, rsp_depart_ff;
   logic [CW-1:0]          rsp_occ_ff;

   logic [SW-1:0]          arr_sum, dep_sum, e2e_sum;
   logic [SUM_WIDTH:0]     ws_sum;
   logic [TIME_WIDTH-1:0]  depart, e2e;
   logic [CW-1:0]          count, cap_eff, occ_after;
   logic [TIME_WIDTH-1:0]  head_time;
   logic                   req_take, pop, dropped, commit_go;
   dtq_fifo_ctrl_type      fifo_ctrl;

   // Saturating arrival time
   assign arr_sum    = SW'(req_gen_time) + SW'(ingress_ff);
   assign arrival_in = (|arr_sum[SW-1:TIME_WIDTH]) ? TIME_MAX : arr_sum[TIME_WIDTH-1:0];

   // Retire the head while it has departed by the arrival
   assign pop = (state_ff == ST_LOOK) && (count != '0) && (head_time <= arrival_ff);

   // Service start and wait against the server's free time
   assign start_in  = (arrival_ff > server_free_ff) ? arrival_ff : server_free_ff;
   assign qdelay_in = (server_free_ff > arrival_ff) ? server_free_ff - arrival_ff : '0;

   // Clamp the capacity into one to the queue depth
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = CW'(1);
      end else if (32'(capacity_ff) > 32'(QUEUE_DEPTH)) begin
         cap_eff = DEPTH_CNT;
      end else begin
         cap_eff = CW'(capacity_ff);
      end
   end

   assign dropped   = count >= cap_eff;
   assign commit_go = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE) || commit_go;
   assign req_take  = req_valid && req_ready;

   // Departure, end-to-end delay and wait sum, all saturating
   assign dep_sum   = SW'(start_ff) + SW'(service_ff);
   assign depart    = (|dep_sum[SW-1:TIME_WIDTH]) ? TIME_MAX : dep_sum[TIME_WIDTH-1:0];
   assign e2e_sum   = SW'(fixed_ff) + SW'(qdelay_ff);
   assign e2e       = (|e2e_sum[SW-1:TIME_WIDTH]) ? TIME_MAX : e2e_sum[TIME_WIDTH-1:0];
   assign ws_sum    = (SUM_WIDTH + 1)'(wait_sum_ff) + (SUM_WIDTH + 1)'(qdelay_ff);
   assign occ_after = dropped ? count : count + 1'b1;

   assign fifo_ctrl.pop  = pop;
   assign fifo_ctrl.push = commit_go && !dropped;

   dtq_fifo #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (fifo_ctrl),
      .push_time (depart),
      .count     (count),
      .head_time (head_time)
   );

   // Sequence one item: look, retire, commit
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (!pop) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (commit_go) begin
               state_in = req_take ? ST_LOOK : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Update statistics at commit
   always_comb begin
      peak_in     = peak_ff;
      accepted_in = accepted_ff;
      discard_in  = discard_ff;
      wait_sum_in = wait_sum_ff;
      if (commit_go) begin
         if (dropped) begin
            if (discard_ff != TOTAL_MAX) begin
               discard_in = discard_ff + 1'b1;
            end
         end else begin
            if (occ_after > peak_ff) begin
               peak_in = occ_after;
            end
            if (accepted_ff != TOTAL_MAX) begin
               accepted_in = accepted_ff + 1'b1;
            end
            wait_sum_in = ws_sum[SUM_WIDTH] ? SUM_MAX : ws_sum[SUM_WIDTH-1:0];
         end
      end
   end

   // Control state, statistics and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         server_free_ff <= '0;
         peak_ff        <= '0;
         accepted_ff    <= '0;
         discard_ff     <= '0;
         wait_sum_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         ingress_ff     <= INGRESS_DELAY_RESET;
         service_ff     <= SERVICE_TIME_RESET;
         capacity_ff    <= QUEUE_CAPACITY_RESET;
         fixed_ff       <= FIXED_PATH_DELAY_RESET;
      end else begin
         state_ff    <= state_in;
         peak_ff     <= peak_in;
         accepted_ff <= accepted_in;
         discard_ff  <= discard_in;
         wait_sum_ff <= wait_sum_in;
         if (fifo_ctrl.push) begin
            server_free_ff <= depart;
         end
         if (commit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_INGRESS_DELAY:    ingress_ff  <= csr_wdata;
               CSR_SERVICE_TIME:     service_ff  <= csr_wdata;
               CSR_QUEUE_CAPACITY:   capacity_ff <= csr_wdata[CAP_WIDTH-1:0];
               CSR_FIXED_PATH_DELAY: fixed_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Item payload and result registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         arrival_ff <= arrival_in;
      end
      if (state_ff == ST_LOOK) begin
         start_ff  <= start_in;
         qdelay_ff <= qdelay_in;
      end
      if (commit_go) begin
         rsp_dropped_ff <= dropped;
         rsp_qdelay_ff  <= dropped ? '0 : qdelay_ff;
         rsp_e2e_ff     <= dropped ? '0 : e2e;
         rsp_depart_ff  <= dropped ? '0 : depart;
         rsp_occ_ff     <= occ_after;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_was_dropped       = rsp_dropped_ff;
   assign rsp_queue_delay       = rsp_qdelay_ff;
   assign rsp_end_to_end_delay  = rsp_e2e_ff;
   assign rsp_depart_time       = rsp_depart_ff;
   assign rsp_occupancy         = rsp_occ_ff;
   assign rsp_peak_occupancy    = peak_ff;
   assign rsp_delivered_total   = accepted_ff;
   assign rsp_dropped_total     = discard_ff;
   assign rsp_queue_delay_total = wait_sum_ff;

endmodule

[src/dtq_checker.sv]
module dtq_checker import dtq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TIME_WIDTH  = 48,
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_was_dropped,
   input logic [TIME_WIDTH-1:0]      rsp_queue_delay,
   input logic [TIME_WIDTH-1:0]      rsp_end_to_end_delay,
   input logic [TIME_WIDTH-1:0]      rsp_depart_time,
   input logic [CW-1:0]              rsp_occupancy,
   input logic [CW-1:0]              rsp_peak_occupancy,
   input logic [TOTAL_WIDTH-1:0]     rsp_delivered_total,
   input logic [SUM_WIDTH-1:0]       rsp_queue_delay_total
);

   logic                   seen_ff;
   logic [TOTAL_WIDTH-1:0] last_del_ff;
   logic [SUM_WIDTH-1:0]   last_sum_ff;

   // Hold the totals of the last delivered item
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         last_del_ff <= rsp_delivered_total;
         last_sum_ff <= rsp_queue_delay_total;
      end
   end

   // A stalled result item stays valid and holds its departure time and delay total
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_depart_time)
         && $stable(rsp_queue_delay_total))
      else $error("result item changed while stalled");

   // A dropped packet carries no timing
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_dropped |-> rsp_queue_delay == '0
         && rsp_end_to_end_delay == '0 && rsp_depart_time == '0)
      else $error("dropped item with non-zero timing");

   // Every result item sees a queue no fuller than the peak; an accepted one a non-empty queue
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occupancy <= rsp_peak_occupancy
         && (rsp_was_dropped || rsp_occupancy != '0))
      else $error("occupancy inconsistent with peak");

   // Totals never fall between delivered items
   a_totals: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && seen_ff |-> rsp_delivered_total >= last_del_ff
         && rsp_queue_delay_total >= last_sum_ff)
      else $error("running total decreased");

endmodule

bind drop_tail_queue_delay_model_top dtq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH),
   .TIME_WIDTH  (TIME_WIDTH)
) u_dtq_checker (.*);
